// ===== rtl/straight_alpha_over_blend_unit_assert.svh =====
// Assertion shorthands for the straight alpha over blend unit.
// Each expects clk and arst_n in scope.
`ifndef STRAIGHT_ALPHA_OVER_BLEND_UNIT_ASSERT_SVH
`define STRAIGHT_ALPHA_OVER_BLEND_UNIT_ASSERT_SVH

// same-cycle implication
`define SAO_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SAO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sao_pkg.sv =====
package sao_pkg;

	localparam int NCH = 3;            // color channels r, g, b
	localparam int NUM_W = 18;         // rounded numerator, max 65152
	localparam logic [7:0] FULL_ALPHA = 8'd255;
	localparam logic [7:0] HALF_DIV = 8'd127;

	// floor(x/255) = (x * OA_RECIP) >> OA_SHIFT for x < 66052
	localparam logic [15:0] OA_RECIP = 16'd32897;
	localparam int OA_SHIFT = 23;
	// floor(x/255) = (x * DD_RECIP) >> DD_SHIFT for x < 16909320
	localparam logic [23:0] DD_RECIP = 24'd8421505;
	localparam int DD_SHIFT = 31;

	localparam int MID_DEPTH = 4;
	localparam int MID_PTR_W = $clog2(MID_DEPTH);
	localparam int OUT_DEPTH = 2;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int FRONT_STAGES = 4;
	localparam int BACK_STAGES = 5;
	localparam int CAPACITY = FRONT_STAGES + MID_DEPTH + BACK_STAGES + OUT_DEPTH;
	localparam int INFLIGHT_W = $clog2(CAPACITY + 1) + 1;

	typedef enum logic {
		KIND_BLEND,
		KIND_PASS
	} kind_t;

	// item handed from front to back
	typedef struct packed {
		kind_t                       kind;
		logic [31:0]                 pixel;   // result when kind is pass
		logic [7:0]                  oa;
		logic [NCH-1:0][NUM_W-1:0]   num;     // numerator incl. oa/2
	} mid_t;

	// divider stage contents
	typedef struct packed {
		kind_t                       kind;
		logic [31:0]                 pixel;
		logic [7:0]                  oa;
		logic [NCH-1:0]              sat;
		logic [NCH-1:0][NUM_W-1:0]   rem;
		logic [NCH-1:0][7:0]         quo;
	} bst_t;

	function automatic bst_t bst_init(mid_t m);
		bst_t b;
		b.kind = m.kind;
		b.pixel = m.pixel;
		b.oa = m.oa;
		b.rem = m.num;
		b.quo = '0;
		for (int c = 0; c < NCH; c++) begin
			b.sat[c] = m.num[c] >= NUM_W'({m.oa, 8'h00});
		end
		return b;
	endfunction

	// one restoring step at quotient bit sh
	function automatic bst_t div_step(bst_t b, logic [2:0] sh);
		bst_t r;
		logic [NUM_W-1:0] dv;
		r = b;
		dv = NUM_W'(b.oa) << sh;
		for (int c = 0; c < NCH; c++) begin
			if (b.rem[c] >= dv) begin
				r.rem[c] = b.rem[c] - dv;
				r.quo[c][sh] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic bst_t div_pair(bst_t b, logic [2:0] hi);
		return div_step(div_step(b, hi), hi - 3'd1);
	endfunction

	function automatic logic [31:0] bst_pixel(bst_t b);
		logic [31:0] p;
		p = b.pixel;
		if (b.kind == KIND_BLEND) begin
			p[31:24] = b.oa;
			for (int c = 0; c < NCH; c++) begin
				p[8*c +: 8] = b.sat[c] ? FULL_ALPHA : b.quo[c];
			end
		end
		return p;
	endfunction

endpackage

// ===== rtl/sao_front.sv =====
module sao_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [31:0]     dst_pixel,
	input  logic [31:0]     src_pixel,
	output logic            q_push,
	input  logic            q_full,
	output sao_pkg::mid_t   q_item
);

	logic advance;
	logic v_s1_q, v_s2_q, v_s3_q, v_s4_q;

	// stage 1: input capture
	logic [31:0] dst_s1, src_s1;

	// stage 1 logic: classify, first products
	logic [7:0] sa, da, inv;
	sao_pkg::kind_t kind_c1;
	logic [31:0] pix_c1;
	logic [sao_pkg::NCH-1:0][15:0] sprod_c1, dprod_c1;
	logic [15:0] ainv_c1;

	sao_pkg::kind_t kind_s2;
	logic [31:0] pix_s2;
	logic [7:0] sa_s2, inv_s2;
	logic [sao_pkg::NCH-1:0][15:0] sprod_s2, dprod_s2;
	logic [15:0] ainv_s2;

	// stage 2 logic
	logic [sao_pkg::NCH-1:0][23:0] ddi_c2;
	logic [16:0] oa_x_c2;
	logic [32:0] oa_m_c2;

	sao_pkg::kind_t kind_s3;
	logic [31:0] pix_s3;
	logic [7:0] sa_s3;
	logic [sao_pkg::NCH-1:0][15:0] sprod_s3;
	logic [sao_pkg::NCH-1:0][23:0] ddi_s3;
	logic [32:0] oa_m_s3;

	// stage 3 logic
	logic [8:0] oa_sum_c3;
	logic [sao_pkg::NCH-1:0][24:0] x_c3;
	logic [sao_pkg::NCH-1:0][48:0] prod_c3;

	sao_pkg::kind_t kind_s4;
	logic [31:0] pix_s4;
	logic [7:0] oa_s4;
	logic [sao_pkg::NCH-1:0][15:0] sprod_s4;
	logic [sao_pkg::NCH-1:0][48:0] prod_s4;

	assign advance = !(v_s4_q && q_full);
	assign full = !advance;
	assign q_push = v_s4_q && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
			v_s4_q <= 1'b0;
		end else if (advance) begin
			v_s1_q <= push;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
			v_s4_q <= v_s3_q;
		end
	end

	always_comb begin
		sa = src_s1[31:24];
		da = dst_s1[31:24];
		inv = sao_pkg::FULL_ALPHA - sa;
		if (sa == sao_pkg::FULL_ALPHA || da == 8'd0) begin
			kind_c1 = sao_pkg::KIND_PASS;
			pix_c1 = src_s1;
		end else if (sa == 8'd0) begin
			kind_c1 = sao_pkg::KIND_PASS;
			pix_c1 = dst_s1;
		end else begin
			kind_c1 = sao_pkg::KIND_BLEND;
			pix_c1 = dst_s1;
		end
		for (int c = 0; c < sao_pkg::NCH; c++) begin
			sprod_c1[c] = 16'(src_s1[8*c +: 8]) * 16'(sa);
			dprod_c1[c] = 16'(dst_s1[8*c +: 8]) * 16'(da);
		end
		ainv_c1 = 16'(da) * 16'(inv);
	end

	always_comb begin
		for (int c = 0; c < sao_pkg::NCH; c++) begin
			ddi_c2[c] = 24'(dprod_s2[c]) * 24'(inv_s2);
		end
		oa_x_c2 = 17'(ainv_s2) + 17'(sao_pkg::HALF_DIV);
		oa_m_c2 = 33'(oa_x_c2) * 33'(sao_pkg::OA_RECIP);
	end

	always_comb begin
		oa_sum_c3 = 9'(sa_s3) + 9'(oa_m_s3[sao_pkg::OA_SHIFT +: 8]);
		for (int c = 0; c < sao_pkg::NCH; c++) begin
			x_c3[c] = 25'(ddi_s3[c]) + 25'(sao_pkg::HALF_DIV);
			prod_c3[c] = 49'(x_c3[c]) * 49'(sao_pkg::DD_RECIP);
		end
	end

	// stage 4: finish numerators, hand over
	always_comb begin
		q_item.kind = kind_s4;
		q_item.pixel = pix_s4;
		q_item.oa = oa_s4;
		for (int c = 0; c < sao_pkg::NCH; c++) begin
			q_item.num[c] = sao_pkg::NUM_W'(sprod_s4[c])
				+ sao_pkg::NUM_W'(prod_s4[c][sao_pkg::DD_SHIFT +: 16])
				+ sao_pkg::NUM_W'(oa_s4 >> 1);
		end
		// guards the divider; cannot happen for a blended pair
		if (kind_s4 == sao_pkg::KIND_BLEND && oa_s4 == 8'd0) begin
			q_item.kind = sao_pkg::KIND_PASS;
			q_item.pixel = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dst_s1 <= dst_pixel;
			src_s1 <= src_pixel;

			kind_s2 <= kind_c1;
			pix_s2 <= pix_c1;
			sa_s2 <= sa;
			inv_s2 <= inv;
			sprod_s2 <= sprod_c1;
			dprod_s2 <= dprod_c1;
			ainv_s2 <= ainv_c1;

			kind_s3 <= kind_s2;
			pix_s3 <= pix_s2;
			sa_s3 <= sa_s2;
			sprod_s3 <= sprod_s2;
			ddi_s3 <= ddi_c2;
			oa_m_s3 <= oa_m_c2;

			kind_s4 <= kind_s3;
			pix_s4 <= pix_s3;
			oa_s4 <= oa_sum_c3[7:0];
			sprod_s4 <= sprod_s3;
			prod_s4 <= prod_c3;
		end
	end

endmodule

// ===== rtl/sao_queue.sv =====
module sao_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	output logic            full,
	input  sao_pkg::mid_t   wr_item,
	input  logic            rd,
	output logic            empty,
	output sao_pkg::mid_t   rd_item
);

	sao_pkg::mid_t mem_q [sao_pkg::MID_DEPTH];
	logic [sao_pkg::MID_PTR_W-1:0] wp_q, rp_q;
	logic [sao_pkg::MID_PTR_W:0] cnt_q;
	logic do_wr, do_rd;

	assign full = cnt_q == (sao_pkg::MID_PTR_W + 1)'(sao_pkg::MID_DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_item;
	end

endmodule

// ===== rtl/sao_back.sv =====
module sao_back (
	input  logic            clk,
	input  logic            arst_n,
	input  sao_pkg::mid_t   q_item,
	input  logic            q_empty,
	output logic            q_pop,
	output logic [31:0]     out_pixel,
	output logic            empty,
	input  logic            pop
);

	logic advance;
	logic v_s1_q, v_s2_q, v_s3_q, v_s4_q, v_s5_q;
	sao_pkg::bst_t b_s1, b_s2, b_s3, b_s4, b_s5;

	logic [31:0] oq_mem_q [sao_pkg::OUT_DEPTH];
	logic [sao_pkg::OUT_PTR_W-1:0] oq_wp_q, oq_rp_q;
	logic [sao_pkg::OUT_PTR_W:0] oq_cnt_q;
	logic oq_full, oq_wr, oq_rd;

	assign oq_full = oq_cnt_q == (sao_pkg::OUT_PTR_W + 1)'(sao_pkg::OUT_DEPTH);
	assign advance = !(v_s5_q && oq_full);
	assign q_pop = advance && !q_empty;
	assign oq_wr = v_s5_q && !oq_full;
	assign oq_rd = pop && !empty;
	assign empty = oq_cnt_q == '0;
	assign out_pixel = oq_mem_q[oq_rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
			v_s4_q <= 1'b0;
			v_s5_q <= 1'b0;
		end else if (advance) begin
			v_s1_q <= !q_empty;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
			v_s4_q <= v_s3_q;
			v_s5_q <= v_s4_q;
		end
	end

	// two quotient bits per stage, msb first
	always_ff @(posedge clk) begin
		if (advance) begin
			b_s1 <= sao_pkg::bst_init(q_item);
			b_s2 <= sao_pkg::div_pair(b_s1, 3'd7);
			b_s3 <= sao_pkg::div_pair(b_s2, 3'd5);
			b_s4 <= sao_pkg::div_pair(b_s3, 3'd3);
			b_s5 <= sao_pkg::div_pair(b_s4, 3'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wp_q <= '0;
			oq_rp_q <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_wr) oq_wp_q <= oq_wp_q + 1'b1;
			if (oq_rd) oq_rp_q <= oq_rp_q + 1'b1;
			if (oq_wr && !oq_rd) oq_cnt_q <= oq_cnt_q + 1'b1;
			else if (oq_rd && !oq_wr) oq_cnt_q <= oq_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (oq_wr) oq_mem_q[oq_wp_q] <= sao_pkg::bst_pixel(b_s5);
	end

endmodule

// ===== rtl/straight_alpha_over_blend_unit.sv =====
// channel   dir  handshake        payload
// input     in   push / full      dst_pixel[31:0], src_pixel[31:0]
// result    out  empty / pop      out_pixel[31:0]
//
// One pixel pair per clock sustained while nothing stalls; each item passes through
// four front stages, the mid queue, five divider stages and the result queue before
// it is shown on out_pixel. The divider retires two quotient bits per
// stage. Reset clears all valid bits and queue counts; no item is in flight after it.
// A stall on pop fills the result queue, then the divider, then the mid queue,
// and only then raises full.
module straight_alpha_over_blend_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] dst_pixel,
	input  logic [31:0] src_pixel,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] out_pixel
);

	logic mq_wr, mq_full, mq_rd, mq_empty;
	sao_pkg::mid_t mq_wr_item, mq_rd_item;

	sao_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.dst_pixel (dst_pixel),
		.src_pixel (src_pixel),
		.q_push    (mq_wr),
		.q_full    (mq_full),
		.q_item    (mq_wr_item)
	);

	sao_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mq_wr),
		.full    (mq_full),
		.wr_item (mq_wr_item),
		.rd      (mq_rd),
		.empty   (mq_empty),
		.rd_item (mq_rd_item)
	);

	sao_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_item    (mq_rd_item),
		.q_empty   (mq_empty),
		.q_pop     (mq_rd),
		.out_pixel (out_pixel),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

// ===== rtl/sao_checker.sv =====
`include "straight_alpha_over_blend_unit_assert.svh"

module sao_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [31:0] out_pixel
);

	logic [sao_pkg::INFLIGHT_W-1:0] inflight_q;
	logic in_xfer, out_xfer, over_cap;

	assign in_xfer = push && !full;
	assign out_xfer = pop && !empty;
	assign over_cap = inflight_q > sao_pkg::INFLIGHT_W'(sao_pkg::CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_xfer && !in_xfer) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	`SAO_ASSERT_IMPL(a_no_phantom, !empty, inflight_q != '0, "result without an accepted item")
	`SAO_ASSERT_IMPL(a_full_busy, full, inflight_q != '0, "full with nothing in flight")
	`SAO_ASSERT_IMPL(a_bounded, 1'b1, !over_cap, "more items in flight than storage")
	`SAO_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_pixel), "stalled result changed")

endmodule

bind straight_alpha_over_blend_unit sao_checker u_sao_checker (.*);

// ===== dv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ALPHA_OPAQUE = 255;
	localparam int unsigned ROUND_BIAS = 127;
	localparam int RANDOM_PAIRS = 1250;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic [31:0] dst;
		logic [31:0] src;
		bit          drain;   // hold off until every prior result is back
	} pixel_pair_t;

	logic        clk;
	logic        arst_n;
	logic        push = 1'b0;
	logic        full;
	logic [31:0] dst_pixel = '0;
	logic [31:0] src_pixel = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] out_pixel;

	pixel_pair_t pair_q[$];
	logic [31:0] composite_q[$];
	int          pairs_total = 0;
	int          sent_cnt = 0;
	int          got_cnt = 0;
	int          errors = 0;

	straight_alpha_over_blend_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.dst_pixel (dst_pixel),
		.src_pixel (src_pixel),
		.empty     (empty),
		.pop       (pop),
		.out_pixel (out_pixel)
	);

	// source-over with straight alpha, rounded as the hardware does
	function automatic logic [31:0] over_composite(logic [31:0] dst, logic [31:0] src);
		int unsigned sa, da, inv, oa, s, d, num, q;
		logic [31:0] res;
		sa = 32'(src[31:24]);
		da = 32'(dst[31:24]);
		if (sa == ALPHA_OPAQUE || da == 0)
			return src;
		if (sa == 0)
			return dst;
		inv = ALPHA_OPAQUE - sa;
		oa = sa + (da * inv + ROUND_BIAS) / ALPHA_OPAQUE;
		if (oa == 0)
			return '0;
		res = '0;
		res[31:24] = oa[7:0];
		for (int c = 0; c < 3; c++) begin
			s = 32'(src[8*c +: 8]);
			d = 32'(dst[8*c +: 8]);
			num = s * sa + (d * da * inv + ROUND_BIAS) / ALPHA_OPAQUE;
			q = (num + oa / 2) / oa;
			if (q > 255)
				q = 255;
			res[8*c +: 8] = q[7:0];
		end
		return res;
	endfunction

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_pair(logic [31:0] dst, logic [31:0] src, bit drain);
		pixel_pair_t p;
		p.dst = dst;
		p.src = src;
		p.drain = drain;
		pair_q.insert(pair_q.size(), p);
		pairs_total++;
	endtask

	function automatic logic [7:0] pick_blend_alpha(int unsigned lo);
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return lo[7:0];
		if (r < 10)
			return 8'd254;
		if (r < 13)
			return 8'd255;
		return 8'($urandom_range(lo, 254));
	endfunction

	function automatic logic [23:0] pick_color();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 24'hffffff;
		if (r == 1)
			return 24'h000000;
		return 24'($urandom());
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#4ms;
		$display("tb failed");
		$finish;
	end

	// sender
	always @(posedge clk) begin : drive
		int gap_left;
		int burst_left;
		bit go;
		pixel_pair_t nxt;
		if (arst_n) begin
			go = 1'b0;
			if (push && !full) begin
				composite_q.insert(composite_q.size(), over_composite(dst_pixel, src_pixel));
				sent_cnt <= sent_cnt + 1;
				if (burst_left > 0) begin
					burst_left--;
					gap_left = 0;
				end else if ($urandom_range(0, 49) == 0) begin
					burst_left = $urandom_range(20, 60);
					gap_left = 0;
				end else begin
					gap_left = pick_gap();
				end
			end else if (push) begin
				go = 1'b1;
			end
			if (!go) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pair_q.size() != 0) begin
					// sent_cnt/got_cnt are read before this edge's updates
					if (!pair_q[0].drain || (got_cnt == sent_cnt && !(push && !full))) begin
						nxt = pair_q.pop_front();
						dst_pixel <= nxt.dst;
						src_pixel <= nxt.src;
						go = 1'b1;
					end
				end
			end
			push <= go;
		end
	end

	// receiver
	always @(posedge clk) begin : watch
		int stall_left;
		int burst_left;
		logic [31:0] want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (composite_q.size() == 0) begin
					$display("%0t: out_pixel %h with no transfer pending", $time, out_pixel);
					errors++;
				end else begin
					want = composite_q.pop_front();
					if (out_pixel !== want) begin
						$display("%0t: out_pixel expected %h actual %h", $time, want, out_pixel);
						errors++;
					end
				end
				got_cnt <= got_cnt + 1;
				if (burst_left > 0) begin
					burst_left--;
					stall_left = 0;
				end else if ($urandom_range(0, 49) == 0) begin
					burst_left = $urandom_range(20, 60);
					stall_left = 0;
				end else begin
					stall_left = pick_gap();
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int r;
		logic [7:0] sa, da;
		// opaque source and transparent destination pass the source through
		add_pair(32'h00000000, 32'h00000000, 1'b0);
		add_pair(32'hffffffff, 32'hffffffff, 1'b0);
		add_pair(32'h80123456, 32'hffabcdef, 1'b0);
		add_pair(32'h00ffffff, 32'h40102030, 1'b0);
		add_pair(32'h00ffffff, 32'hff000000, 1'b0);
		// transparent source keeps the destination
		add_pair(32'hc0a1b2c3, 32'h00ffffff, 1'b0);
		add_pair(32'hffffffff, 32'h00000000, 1'b0);
		add_pair(32'h01000000, 32'h00ffffff, 1'b0);
		// blended pairs; in some the channel quotient rounds up to 256 and must saturate
		add_pair(32'h80ffffff, 32'h01ffffff, 1'b0);
		add_pair(32'hff000000, 32'h01ffffff, 1'b0);
		add_pair(32'h01ffffff, 32'hfe000000, 1'b0);
		add_pair(32'h01ffffff, 32'h01ffffff, 1'b0);
		add_pair(32'h80204060, 32'h80e0c0a0, 1'b0);
		add_pair(32'hff00ff00, 32'hfeff00ff, 1'b0);
		add_pair(32'h80ffffff, 32'h01000000, 1'b0);
		add_pair(32'hff123456, 32'h7f654321, 1'b0);
		add_pair(32'h01000000, 32'hfeffffff, 1'b0);
		add_pair(32'h55aa55aa, 32'haa55aa55, 1'b1);

		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				sa = 8'd255;
				da = 8'($urandom());
			end else if (r < 12) begin
				sa = 8'($urandom());
				da = 8'd0;
			end else if (r < 18) begin
				sa = 8'd0;
				da = 8'($urandom());
			end else begin
				sa = pick_blend_alpha(1);
				da = pick_blend_alpha(1);
				if ($urandom_range(0, 9) == 0)
					da = 8'd255;
			end
			add_pair({da, pick_color()}, {sa, pick_color()}, i == 400 || i == 900);
		end

		wait (arst_n === 1'b1);
		wait (sent_cnt == pairs_total);
		wait (got_cnt == sent_cnt);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && composite_q.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sao_pkg.sv
rtl/sao_front.sv
rtl/sao_queue.sv
rtl/sao_back.sv
rtl/straight_alpha_over_blend_unit.sv
rtl/sao_checker.sv
dv/tb.sv
